// File: hw/rtl/assert_macros.svh
// assertion helpers for the complex arithmetic unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define CAU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cau assertion failed");

// property checked at every edge, reset included
`define CAU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("cau assertion failed");

`else

`define CAU_ASSERT(lbl, clk, rst_n, prop)
`define CAU_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: hw/rtl/cau_pkg.sv
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SUM_W      = PROD_W + 1;
    localparam int QUOT_W     = DATA_WIDTH;
    localparam int NUM_W      = PROD_W + FRAC_BITS;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;

    localparam logic [PROD_W-1:0] MAG_MAX = (PROD_W'(1) << (DATA_WIDTH - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0] MAG_MIN = MAG_MAX + PROD_W'(1);

    typedef struct packed {
        logic [2:0]                   op;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } cau_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_real;
        logic signed [DATA_WIDTH-1:0] res_imag;
        logic                         is_equal;
        logic                         div_zero;
        logic                         overflow;
    } cau_out_t;

    // one divider lane slot, non-divide results ride along in res
    typedef struct packed {
        logic                  is_div;
        logic                  neg_re;
        logic                  neg_im;
        logic                  sat_re;
        logic                  sat_im;
        logic [PROD_W-1:0]     den;
        logic [PROD_W-1:0]     rem_re;
        logic [PROD_W-1:0]     rem_im;
        logic [QUOT_W-1:0]     sh_re;
        logic [QUOT_W-1:0]     sh_im;
        cau_out_t              res;
    } cau_div_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  ovf;
    } cau_sat_t;

    // clamp a sign-magnitude value to the signed data range
    function automatic cau_sat_t cau_saturate(input logic neg, input logic [PROD_W-1:0] mag,
                                              input logic force_sat);
        cau_sat_t          r;
        logic [PROD_W-1:0] twos;
        twos = PROD_W'(0) - mag;
        if (!neg) begin
            if (force_sat || (mag > MAG_MAX)) begin
                r.val = MAG_MAX[DATA_WIDTH-1:0];
                r.ovf = 1'b1;
            end else begin
                r.val = mag[DATA_WIDTH-1:0];
                r.ovf = 1'b0;
            end
        end else begin
            if (force_sat || (mag > MAG_MIN)) begin
                r.val = MAG_MIN[DATA_WIDTH-1:0];
                r.ovf = 1'b1;
            end else begin
                r.val = twos[DATA_WIDTH-1:0];
                r.ovf = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/cau_front.sv
module cau_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  cau_pkg::cau_in_t in_data,
    output logic             out_valid,
    output cau_pkg::cau_div_t out_data
);
    import cau_pkg::*;

    // stage 1: operand register
    logic    v1_reg;
    cau_in_t in1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in1_reg <= in_data;
        end
    end

    // stage 2: products, plus add, subtract and equality results
    logic                     v2_reg;
    logic [2:0]               op2_reg;
    logic signed [PROD_W-1:0] prr_reg, pii_reg, pri_reg, pir_reg, pbr_reg, pbi_reg;
    logic signed [PROD_W-1:0] prr_next, pii_next, pri_next, pir_next, pbr_next, pbi_next;
    cau_out_t                 d2_reg, d2_next;
    logic signed [DATA_WIDTH:0] sum_s;
    logic [DATA_WIDTH:0]      sum_mag;
    cau_sat_t                 sat_r, sat_i;
    logic signed [DATA_WIDTH:0] sum_i;
    logic [DATA_WIDTH:0]      sum_imag_mag;

    assign prr_next = PROD_W'(in1_reg.a_real) * PROD_W'(in1_reg.b_real);
    assign pii_next = PROD_W'(in1_reg.a_imag) * PROD_W'(in1_reg.b_imag);
    assign pri_next = PROD_W'(in1_reg.a_real) * PROD_W'(in1_reg.b_imag);
    assign pir_next = PROD_W'(in1_reg.a_imag) * PROD_W'(in1_reg.b_real);
    assign pbr_next = PROD_W'(in1_reg.b_real) * PROD_W'(in1_reg.b_real);
    assign pbi_next = PROD_W'(in1_reg.b_imag) * PROD_W'(in1_reg.b_imag);

    always_comb begin
        if (in1_reg.op == OP_SUB) begin
            sum_s = (DATA_WIDTH+1)'(in1_reg.a_real) - (DATA_WIDTH+1)'(in1_reg.b_real);
            sum_i = (DATA_WIDTH+1)'(in1_reg.a_imag) - (DATA_WIDTH+1)'(in1_reg.b_imag);
        end else begin
            sum_s = (DATA_WIDTH+1)'(in1_reg.a_real) + (DATA_WIDTH+1)'(in1_reg.b_real);
            sum_i = (DATA_WIDTH+1)'(in1_reg.a_imag) + (DATA_WIDTH+1)'(in1_reg.b_imag);
        end
        sum_mag      = sum_s[DATA_WIDTH] ? ((DATA_WIDTH+1)'(0) - sum_s) : sum_s;
        sum_imag_mag = sum_i[DATA_WIDTH] ? ((DATA_WIDTH+1)'(0) - sum_i) : sum_i;
        sat_r = cau_saturate(sum_s[DATA_WIDTH], PROD_W'(sum_mag), 1'b0);
        sat_i = cau_saturate(sum_i[DATA_WIDTH], PROD_W'(sum_imag_mag), 1'b0);
        d2_next = '0;
        case (in1_reg.op)
            OP_ADD, OP_SUB: begin
                d2_next.res_real = sat_r.val;
                d2_next.res_imag = sat_i.val;
                d2_next.overflow = sat_r.ovf | sat_i.ovf;
            end
            OP_EQ: begin
                d2_next.is_equal = (in1_reg.a_real == in1_reg.b_real)
                                && (in1_reg.a_imag == in1_reg.b_imag);
            end
            default: begin
                d2_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op2_reg <= in1_reg.op;
            prr_reg <= prr_next;
            pii_reg <= pii_next;
            pri_reg <= pri_next;
            pir_reg <= pir_next;
            pbr_reg <= pbr_next;
            pbi_reg <= pbi_next;
            d2_reg  <= d2_next;
        end
    end

    // stage 3: cross sums and squared magnitude
    logic                    v3_reg;
    logic [2:0]              op3_reg;
    logic signed [SUM_W-1:0] x_reg, y_reg, x_next, y_next;
    logic [PROD_W-1:0]       den_reg, den_next;
    cau_out_t                d3_reg;

    always_comb begin
        if (op2_reg == OP_DIV) begin
            x_next = SUM_W'(prr_reg) + SUM_W'(pii_reg);
            y_next = SUM_W'(pir_reg) - SUM_W'(pri_reg);
        end else begin
            x_next = SUM_W'(prr_reg) - SUM_W'(pii_reg);
            y_next = SUM_W'(pri_reg) + SUM_W'(pir_reg);
        end
        den_next = $unsigned(pbr_reg) + $unsigned(pbi_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op3_reg <= op2_reg;
            x_reg   <= x_next;
            y_reg   <= y_next;
            den_reg <= den_next;
            d3_reg  <= d2_reg;
        end
    end

    // stage 4: magnitudes, multiply result, divider set-up
    logic              v4_reg;
    cau_div_t          q4_reg, q4_next;
    logic [SUM_W-1:0]  xm_full, ym_full;
    logic [PROD_W-1:0] xm, ym;
    logic [NUM_W-1:0]  nx, ny;
    logic [PROD_W-1:0] rx0, ry0;
    cau_sat_t          mr, mi;

    always_comb begin
        xm_full = x_reg[SUM_W-1] ? (SUM_W'(0) - x_reg) : x_reg;
        ym_full = y_reg[SUM_W-1] ? (SUM_W'(0) - y_reg) : y_reg;
        xm = xm_full[PROD_W-1:0];
        ym = ym_full[PROD_W-1:0];
        nx = {xm, {FRAC_BITS{1'b0}}};
        ny = {ym, {FRAC_BITS{1'b0}}};
        rx0 = PROD_W'(nx[NUM_W-1:QUOT_W]);
        ry0 = PROD_W'(ny[NUM_W-1:QUOT_W]);
        mr = cau_saturate(x_reg[SUM_W-1], xm >> FRAC_BITS, 1'b0);
        mi = cau_saturate(y_reg[SUM_W-1], ym >> FRAC_BITS, 1'b0);

        q4_next        = '0;
        q4_next.neg_re = x_reg[SUM_W-1];
        q4_next.neg_im = y_reg[SUM_W-1];
        q4_next.sat_re = rx0 >= den_reg;
        q4_next.sat_im = ry0 >= den_reg;
        q4_next.den    = den_reg;
        q4_next.rem_re = rx0;
        q4_next.rem_im = ry0;
        q4_next.sh_re  = nx[QUOT_W-1:0];
        q4_next.sh_im  = ny[QUOT_W-1:0];
        q4_next.res    = d3_reg;
        case (op3_reg)
            OP_MUL: begin
                q4_next.res.res_real = mr.val;
                q4_next.res.res_imag = mi.val;
                q4_next.res.overflow = mr.ovf | mi.ovf;
            end
            OP_DIV: begin
                if (den_reg == '0) begin
                    q4_next.res.div_zero = 1'b1;
                end else begin
                    q4_next.is_div = 1'b1;
                end
            end
            default: begin
                q4_next.res = d3_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q4_reg <= q4_next;
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = q4_reg;

endmodule

// File: hw/rtl/cau_div_step.sv
module cau_div_step (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::cau_div_t in_data,
    output logic              out_valid,
    output cau_pkg::cau_div_t out_data
);
    import cau_pkg::*;

    logic            valid_reg;
    cau_div_t        data_reg, data_next;
    logic [PROD_W:0] trial_re, trial_im;
    logic            bit_re, bit_im;

    // one restoring quotient bit per part
    always_comb begin
        trial_re = {in_data.rem_re, in_data.sh_re[QUOT_W-1]};
        trial_im = {in_data.rem_im, in_data.sh_im[QUOT_W-1]};
        bit_re = trial_re >= {1'b0, in_data.den};
        bit_im = trial_im >= {1'b0, in_data.den};
        data_next = in_data;
        if (bit_re) begin
            data_next.rem_re = PROD_W'(trial_re - {1'b0, in_data.den});
        end else begin
            data_next.rem_re = trial_re[PROD_W-1:0];
        end
        if (bit_im) begin
            data_next.rem_im = PROD_W'(trial_im - {1'b0, in_data.den});
        end else begin
            data_next.rem_im = trial_im[PROD_W-1:0];
        end
        data_next.sh_re = {in_data.sh_re[QUOT_W-2:0], bit_re};
        data_next.sh_im = {in_data.sh_im[QUOT_W-2:0], bit_im};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/cau_finish.sv
module cau_finish (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  cau_pkg::cau_div_t in_data,
    output logic              out_valid,
    output cau_pkg::cau_out_t out_data
);
    import cau_pkg::*;

    logic     valid_reg;
    cau_out_t res_reg, res_next;
    cau_sat_t qr, qi;

    // quotient clamp for divide, pass-through otherwise
    always_comb begin
        qr = cau_saturate(in_data.neg_re, PROD_W'(in_data.sh_re), in_data.sat_re);
        qi = cau_saturate(in_data.neg_im, PROD_W'(in_data.sh_im), in_data.sat_im);
        if (in_data.is_div) begin
            res_next          = '0;
            res_next.res_real = qr.val;
            res_next.res_imag = qi.val;
            res_next.overflow = qr.ovf | qi.ovf;
        end else begin
            res_next = in_data.res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = res_reg;

endmodule

// File: hw/rtl/complex_arithmetic_unit_core.sv
// structure: 37 register stages from input beat to result beat
// (4 front stages, 32 quotient-bit stages, 1 output register)
// throughput: one beat per cycle; the whole pipe holds while a result waits
// reset: synchronous active-low aresetn clears all stage valid bits only
`include "assert_macros.svh"

module complex_arithmetic_unit_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cau_pkg::cau_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cau_pkg::cau_out_t m_data
);
    import cau_pkg::*;

    logic     en;
    logic     chain_valid [0:QUOT_W];
    cau_div_t chain_data  [0:QUOT_W];
    logic     flags_clash;
    logic     zero_div_clean;

    // pipe advances unless a finished result is held
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    // quotient bit stages
    for (genvar g = 0; g < QUOT_W; g++) begin : g_div
        cau_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_valid[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    cau_finish u_finish (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (chain_valid[QUOT_W]),
        .in_data   (chain_data[QUOT_W]),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // checks
    assign flags_clash    = m_data.is_equal && (m_data.div_zero || m_data.overflow);
    assign zero_div_clean = (m_data.res_real == '0) && (m_data.res_imag == '0)
                         && !m_data.overflow;

    `CAU_ASSERT(a_stall_blocks_input, aclk, aresetn, (m_valid && !m_ready) |-> !s_ready)
    `CAU_ASSERT(a_flags_exclusive, aclk, aresetn, m_valid |-> !flags_clash)
    `CAU_ASSERT(a_div_zero_clean, aclk, aresetn, (m_valid && m_data.div_zero) |-> zero_div_clean)
    `CAU_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid)

endmodule

// File: bench/cau_checker.sv
module cau_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  cau_pkg::cau_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  cau_pkg::cau_out_t m_data,
    output int                fail_count,
    output int                pending,
    output int                results_seen
);
    import cau_pkg::*;

    cau_out_t expected_results[$];

    // sign-magnitude clamp to the 32-bit signed range
    function automatic logic [32:0] clamp_part(input logic neg, input logic [127:0] mag,
                                               input logic force_sat);
        logic [31:0] v;
        logic        o;
        o = 1'b0;
        if (!neg) begin
            if (force_sat || mag > 128'h7fffffff) begin
                mag = 128'h7fffffff;
                o = 1'b1;
            end
            v = mag[31:0];
        end else begin
            if (force_sat || mag > 128'h80000000) begin
                mag = 128'h80000000;
                o = 1'b1;
            end
            v = 32'd0 - mag[31:0];
        end
        return {o, v};
    endfunction

    // clamp a signed wide value
    function automatic logic [32:0] clamp_signed(input logic signed [127:0] v);
        logic [127:0] m;
        m = v < 0 ? -v : v;
        return clamp_part(v < 0, m, 1'b0);
    endfunction

    // truncating quotient with FRAC_BITS fraction bits
    function automatic logic [32:0] divide_part(input logic signed [127:0] num,
                                                input logic [127:0] den);
        logic [127:0] m;
        logic [127:0] q;
        m = num < 0 ? -num : num;
        q = m / den;
        if (q >= 128'h1_0000_0000)
            return clamp_part(num < 0, 128'd0, 1'b1);
        q = (m << FRAC_BITS) / den;
        return clamp_part(num < 0 && q != 0, q, 1'b0);
    endfunction

    function automatic cau_out_t predict_result(input cau_in_t x);
        cau_out_t                r;
        logic signed [127:0]     ar, ai, br, bi, nr, ni;
        logic [127:0]            den, mr, mi;
        logic [32:0]             pr, pi;
        ar = x.a_real;
        ai = x.a_imag;
        br = x.b_real;
        bi = x.b_imag;
        r = '0;
        pr = '0;
        pi = '0;
        case (x.op)
            OP_ADD: begin
                pr = clamp_signed(ar + br);
                pi = clamp_signed(ai + bi);
            end
            OP_SUB: begin
                pr = clamp_signed(ar - br);
                pi = clamp_signed(ai - bi);
            end
            OP_MUL: begin
                nr = ar * br - ai * bi;
                ni = ar * bi + ai * br;
                mr = nr < 0 ? -nr : nr;
                mi = ni < 0 ? -ni : ni;
                mr = mr >> FRAC_BITS;
                mi = mi >> FRAC_BITS;
                pr = clamp_part(nr < 0 && mr != 0, mr, 1'b0);
                pi = clamp_part(ni < 0 && mi != 0, mi, 1'b0);
            end
            OP_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.div_zero = 1'b1;
                end else begin
                    pr = divide_part(ar * br + ai * bi, den);
                    pi = divide_part(ai * br - ar * bi, den);
                end
            end
            OP_EQ: r.is_equal = (ar == br) && (ai == bi);
            default: ;
        endcase
        r.res_real = pr[31:0];
        r.res_imag = pi[31:0];
        r.overflow = pr[32] | pi[32];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got %h want %h", results_seen, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_results.size();

    initial begin
        fail_count = 0;
        results_seen = 0;
    end

    // predict on input beats, compare on result beats
    always @(posedge aclk) begin
        cau_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_result(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", 32'd0, 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.res_real !== want.res_real)
                        report_mismatch("res_real", m_data.res_real, want.res_real);
                    if (m_data.res_imag !== want.res_imag)
                        report_mismatch("res_imag", m_data.res_imag, want.res_imag);
                    if (m_data.is_equal !== want.is_equal)
                        report_mismatch("is_equal", 32'(m_data.is_equal), 32'(want.is_equal));
                    if (m_data.div_zero !== want.div_zero)
                        report_mismatch("div_zero", 32'(m_data.div_zero), 32'(want.div_zero));
                    if (m_data.overflow !== want.overflow)
                        report_mismatch("overflow", 32'(m_data.overflow), 32'(want.overflow));
                end
                results_seen++;
            end
        end
    end
endmodule

// File: bench/tb_top.sv
module tb_top;
    import cau_pkg::*;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cau_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cau_out_t m_data;
    int       fail_count, pending, results_seen;
    int       cycle_count = 0;
    int       items_sent = 0;
    bit       calm = 1'b0;
    bit       hold_off = 1'b0;
    cau_in_t  directed_items[$];

    always #6 aclk = ~aclk;

    complex_arithmetic_unit_core dut (.*);

    cau_checker checker_i (.*);

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("complex_arithmetic_unit_core: mismatch");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off
    always @(posedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 34);
    end

    function automatic logic [31:0] pick_part();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'd0;
            3: return $urandom_range(3) << 16;
            4: return -($urandom_range(3) << 16);
            5: return $urandom & 32'h000fffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic cau_in_t random_item();
        cau_in_t x;
        x.op = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
        x.a_real = pick_part();
        x.a_imag = pick_part();
        x.b_real = pick_part();
        x.b_imag = pick_part();
        if (x.op == OP_EQ && $urandom_range(1)) begin
            x.b_real = x.a_real;
            if ($urandom_range(1)) x.b_imag = x.a_imag;
        end
        if (x.op == OP_DIV && $urandom_range(9) == 0) begin
            x.b_real = 32'd0;
            x.b_imag = 32'd0;
        end
        return x;
    endfunction

    task automatic send_beat(input cau_in_t x);
        s_valid <= 1'b1;
        s_data  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // idle cycles before a beat, about a third of all cycles
    task automatic maybe_idle();
        while (!calm && $urandom_range(99) < 34) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    initial begin
        cau_in_t x;
        // extremes, each operation, zero divisor, equality, unused codes
        directed_items.push_back('{OP_ADD, 32'h7fffffff, 32'h80000000, 32'd1, -32'sd1});
        directed_items.push_back('{OP_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
        directed_items.push_back('{OP_SUB, 32'h80000000, 32'h7fffffff, 32'd1, -32'sd1});
        directed_items.push_back('{OP_SUB, 32'h00010000, 32'h00020000, 32'h00030000, 32'd0});
        directed_items.push_back('{OP_MUL, 32'h00020000, 32'h00030000, 32'h00040000, -32'sh10000});
        directed_items.push_back('{OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
        directed_items.push_back('{OP_MUL, 32'h7fffffff, 32'd0, 32'h7fffffff, 32'd0});
        directed_items.push_back('{OP_MUL, -32'sd1, 32'd0, 32'd1, 32'd0});
        directed_items.push_back('{OP_DIV, 32'h00010000, 32'h00010000, 32'd0, 32'd0});
        directed_items.push_back('{OP_DIV, 32'h00040000, 32'h00020000, 32'h00010000, 32'h00010000});
        directed_items.push_back('{OP_DIV, 32'h7fffffff, 32'h80000000, 32'd1, 32'd0});
        directed_items.push_back('{OP_DIV, -32'sd1, 32'd1, 32'h7fffffff, 32'h80000000});
        directed_items.push_back('{OP_DIV, 32'h80000000, 32'h80000000, 32'd1, 32'd1});
        directed_items.push_back('{OP_EQ, 32'h12345678, -32'sd5, 32'h12345678, -32'sd5});
        directed_items.push_back('{OP_EQ, 32'h12345678, -32'sd5, 32'h12345678, -32'sd4});
        directed_items.push_back('{3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
        directed_items.push_back('{3'd6, 32'd1, 32'd2, 32'd3, 32'd4});
        directed_items.push_back('{3'd7, 32'h80000000, 32'd0, 32'd0, 32'd0});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_items[i]) begin
            maybe_idle();
            send_beat(directed_items[i]);
        end
        s_valid <= 1'b0;
        // pause until the pipe has drained
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        for (int n = 0; n < 1200; n++) begin
            calm = (n >= 400 && n < 600);
            // long receiver hold-off while the sender keeps going
            if (n == 700) begin
                hold_off = 1'b1;
                fork
                    begin
                        repeat (150) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            maybe_idle();
            x = random_item();
            send_beat(x);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);

        $display("sent %0d operand pairs, %0d results checked, all ops with saturation,",
                 items_sent, results_seen);
        $display("zero divisors, unused codes, random stalls and a long output hold-off");
        if (fail_count == 0 && pending == 0)
            $display("complex_arithmetic_unit_core: match");
        else
            $display("complex_arithmetic_unit_core: mismatch");
        $finish;
    end
endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/cau_pkg.sv
hw/rtl/cau_front.sv
hw/rtl/cau_div_step.sv
hw/rtl/cau_finish.sv
hw/rtl/complex_arithmetic_unit_core.sv
bench/cau_checker.sv
bench/tb_top.sv
